/* hw/rtl/bvfc_pkg.sv */
`timescale 1ns / 1ps

package bvfc_pkg;

    // default converter width
    localparam int SAMPLE_BITS_DEF = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE  = 3'd5;

    // field widths
    localparam int VOLT_W  = 16;
    localparam int SCALE_W = 15;
    localparam int OUT_W   = 32;

    // register reset values
    localparam logic [VOLT_W-1:0]  FULL_SCALE_RST = 16'd9293;
    localparam logic [VOLT_W-1:0]  NOMINAL_RST    = 16'd3072;
    localparam logic [VOLT_W-1:0]  COEF_RST       = 16'd3277;
    localparam logic [VOLT_W-1:0]  SNAP_RST       = 16'd256;
    localparam logic [VOLT_W-1:0]  LOW_CUT_RST    = 16'd1792;
    localparam logic [SCALE_W-1:0] MAX_SCALE_RST  = 15'd22938;

    // 1.0 in Q1.14
    localparam logic [SCALE_W-1:0] SCALE_ONE = 15'd16384;

endpackage

/* hw/rtl/battery_voltage_filter_compensation_core.sv */
`timescale 1ns / 1ps
// sequence: a request with a new sample runs the sample multiply, the snap check (a hit skips
// the coefficient multiply and update), then the scale step; a query-only request starts there
// one request at a time: the next is accepted only once the block is back in idle; the
// multipliers and the restoring divider are bit-serial (one bit a cycle); a result still
// waiting in the output register holds the next one in the done state
// reset: synchronous active-low i_rst_n loads register defaults and sets the filter to 3072
module battery_voltage_filter_compensation_core #(
    parameter int SAMPLE_BITS = bvfc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [bvfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bvfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [SAMPLE_BITS-1:0] adc_sample, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // [0] sample_valid
    input  logic                                s_axis_tuser,
    // result side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] filtered_voltage, [30:16] compensation_scale, [31] zero
    output logic [bvfc_pkg::OUT_W-1:0]          m_axis_tdata
);
    import bvfc_pkg::*;

    localparam int CNT_MAX = (SAMPLE_BITS > VOLT_W) ? SAMPLE_BITS : VOLT_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [CNT_W-1:0] MUL_S_LAST = CNT_W'(SAMPLE_BITS - 1);
    localparam logic [CNT_W-1:0] MUL_C_LAST = CNT_W'(VOLT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(SCALE_W - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULS  = 4'd1;
    localparam logic [3:0] S_SNAP  = 4'd2;
    localparam logic [3:0] S_MULC  = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    typedef logic signed [VOLT_W+1:0] t_acc;

    // configuration registers
    logic [VOLT_W-1:0]  r_full_scale;
    logic [VOLT_W-1:0]  r_nominal;
    logic [VOLT_W-1:0]  r_coef;
    logic [VOLT_W-1:0]  r_snap;
    logic [VOLT_W-1:0]  r_low_cut;
    logic [SCALE_W-1:0] r_max_scale;

    // control and state
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [VOLT_W-1:0]  r_filt;
    logic               r_out_valid;

    // datapath shift registers
    logic [VOLT_W-1:0]      r_mhi;
    logic [SAMPLE_BITS-1:0] r_mlo;
    logic signed [VOLT_W:0] r_d;
    t_acc                   r_ehi;
    logic [VOLT_W-1:0]      r_elo;
    logic [VOLT_W-1:0]      r_rem;
    logic [SCALE_W-1:0]     r_quo;
    logic [SCALE_W-1:0]     r_scale;
    logic [VOLT_W-1:0]      r_out_filt;
    logic [SCALE_W-1:0]     r_out_scale;

    // combinational helpers
    logic [VOLT_W:0]        w_msum;
    t_acc                   w_esum;
    t_acc                   w_upd;
    logic [VOLT_W:0]        w_trial;
    logic                   w_qbit;
    logic                   w_in_req;
    logic                   w_out_free;
    logic                   w_snap_hit;
    logic                   w_no_comp;
    logic                   w_overflow;

    assign w_in_req   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // one multiplier bit a cycle: full scale times sample
    assign w_msum = {1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_full_scale} : '0);

    // one coefficient bit a cycle: signed difference times coef
    assign w_esum = r_ehi + (r_elo[0] ? t_acc'(r_d) : t_acc'(0));

    // filter plus rounded high half of the product
    assign w_upd  = t_acc'({2'b00, r_filt}) + r_ehi + t_acc'({17'b0, r_elo[VOLT_W-1]});

    // restoring divide step
    assign w_trial = {r_rem, r_quo[SCALE_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_filt});

    assign w_snap_hit = (r_filt < r_snap) && (r_mhi > r_snap);
    assign w_no_comp  = (r_filt < r_low_cut) || (r_filt > r_nominal) || (r_filt == '0);
    // quotient would need more than SCALE_W bits
    assign w_overflow = ({1'b0, r_nominal} >= {r_filt, 1'b0});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_req) begin
                    n_state = s_axis_tuser ? S_MULS : S_SCALE;
                end
            end
            S_MULS: begin
                if (r_cnt == MUL_S_LAST) begin
                    n_state = S_SNAP;
                end
            end
            S_SNAP: begin
                n_state = w_snap_hit ? S_SCALE : S_MULC;
            end
            S_MULC: begin
                if (r_cnt == MUL_C_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = (w_no_comp || w_overflow) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_filt       <= NOMINAL_RST;
            r_full_scale <= FULL_SCALE_RST;
            r_nominal    <= NOMINAL_RST;
            r_coef       <= COEF_RST;
            r_snap       <= SNAP_RST;
            r_low_cut    <= LOW_CUT_RST;
            r_max_scale  <= MAX_SCALE_RST;
        end else begin
            r_state <= n_state;

            // step counter restarts on every state change
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end

            // filter value updates
            if (r_state == S_SNAP && w_snap_hit) begin
                r_filt <= r_mhi;
            end else if (r_state == S_UPD) begin
                r_filt <= w_upd[VOLT_W-1:0];
            end

            // output register
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FULL_SCALE: r_full_scale <= i_cfg_data;
                    REG_NOMINAL:    r_nominal    <= i_cfg_data;
                    REG_COEF:       r_coef       <= i_cfg_data;
                    REG_SNAP:       r_snap       <= i_cfg_data;
                    REG_LOW_CUT:    r_low_cut    <= i_cfg_data;
                    REG_MAX_SCALE:  r_max_scale  <= i_cfg_data[SCALE_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mhi <= '0;
                r_mlo <= s_axis_tdata[SAMPLE_BITS-1:0];
            end
            S_MULS: begin
                r_mhi <= w_msum[VOLT_W:1];
                r_mlo <= {w_msum[0], r_mlo[SAMPLE_BITS-1:1]};
            end
            S_SNAP: begin
                r_d   <= $signed({1'b0, r_mhi}) - $signed({1'b0, r_filt});
                r_ehi <= '0;
                r_elo <= r_coef;
            end
            S_MULC: begin
                r_ehi <= {w_esum[VOLT_W+1], w_esum[VOLT_W+1:1]};
                r_elo <= {w_esum[0], r_elo[VOLT_W-1:1]};
            end
            S_SCALE: begin
                r_scale <= w_no_comp ? SCALE_ONE : r_max_scale;
                r_rem   <= {1'b0, r_nominal[VOLT_W-1:1]};
                r_quo   <= {r_nominal[0], {(SCALE_W-1){1'b0}}};
            end
            S_DIV: begin
                r_rem <= w_qbit ? w_trial[VOLT_W-1:0] - r_filt : w_trial[VOLT_W-1:0];
                r_quo <= {r_quo[SCALE_W-2:0], w_qbit};
            end
            S_CLAMP: begin
                r_scale <= (r_quo > r_max_scale) ? r_max_scale : r_quo;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_filt  <= r_filt;
                    r_out_scale <= r_scale;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_scale, r_out_filt};

    // one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_req |=> !s_axis_tready)
        else $error("request accepted while busy");

    // results only leave the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result without finished computation");

    // divider never sees a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_filt != '0)
        else $error("division by zero");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_filt)
        else $error("divider remainder out of range");

endmodule
